### rtl/dltq_pkg.sv
// ============================================================================
// dltq_pkg: shared types and constants of the delta-list timer queue
// Operation codes, result codes, controller states and cell commands.
// ============================================================================
package dltq_pkg;

    localparam int NUM_TIMERS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int TID_W   = 4;
    localparam int FIELD_W = 32;

    // expiry reports kept per tick transaction
    localparam int RESULT_CAP = 16;
    localparam int RC_W       = $clog2(RESULT_CAP + 1);

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_ERR      = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP,
        S_INS,
        S_FIND,
        S_RES,
        S_TCHK,
        S_TRLD,
        S_TREP,
        S_TEND
    } t_state;

    typedef enum logic [2:0] {
        C_HOLD,
        C_SUB,
        C_REMOVE,
        C_REMADD,
        C_INSERT
    } t_cell_cmd;

endpackage

### rtl/dltq_if.sv
// ============================================================================
// dltq_if: channel interfaces of the delta-list timer queue
// Valid/ready channels for operation transactions and result transactions.
// ============================================================================
interface dltq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [3:0]  timer_id;
    logic [31:0] count;
    logic [31:0] interval;

    modport source (output valid, operation, timer_id, count, interval, input ready);
    modport sink   (input valid, operation, timer_id, count, interval, output ready);
endinterface

interface dltq_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [3:0] timer_id_res;
    logic       status;
    logic       pending;
    logic       last;

    modport source (output valid, kind, timer_id_res, status, pending, last, input ready);
    modport sink   (input valid, kind, timer_id_res, status, pending, last, output ready);
endinterface

### rtl/delta_list_timer_queue.sv
// ============================================================================
// delta_list_timer_queue: delta-ordered software-style timer queue
// Row of queue cells in expiry order plus a sequencer for tick, start, stop,
// modify and pending query transactions.
// ============================================================================
//  channel   direction  payload
//  i_in      sink       operation, timer_id, count, interval
//  o_out     source     kind, timer_id_res, status, pending, last
//
//  One transaction at a time. Query, refused start/stop/modify, unknown code
//  or timer id out of range: no walk. Start walks the queue (up to NUM_TIMERS
//  cells), stop walks it to search, modify searches if queued, then inserts.
//  Tick: per expired timer a check, reload and report, plus a periodic one's
//  reinsert walk. Walks step one queue cell per cycle. Reset is synchronous,
//  no clearing pass. A stalled o_out holds the sequencer at the next result.
// ============================================================================
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_in_if.sink    i_in,
    dltq_out_if.source o_out
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = COUNT_WIDTH;
    localparam logic [IW:0] NT_X = (IW+1)'(NUM_TIMERS);

    t_state r_state, n_state;

    logic [OP_W-1:0]  r_op;
    logic [IW-1:0]    r_id;
    logic [TID_W-1:0] r_id_raw;
    logic             r_bad;
    logic [CW-1:0]    r_cnt, r_ivl;
    logic             r_st, n_st;
    logic [IW-1:0]    r_w, n_w;
    logic [IW:0]      r_c, n_c;
    logic [IW:0]      r_g, n_g;
    logic             r_left, n_left;
    logic [RC_W-1:0]  r_n, n_n;
    logic [CW-1:0]    r_iv, n_iv;
    logic [IW-1:0]    r_iid, n_iid;
    logic [IW-1:0]    r_t, n_t;
    logic             r_tick, n_tick;
    logic             r_hv, n_hv;
    logic [IW-1:0]    r_h_id, n_h_id;
    logic             r_h_pend, n_h_pend;
    logic [NUM_TIMERS-1:0] r_inq, n_inq;

    logic             r_ov;
    logic             r_o_kind, r_o_st, r_o_pend, r_o_last;
    logic [TID_W-1:0] r_o_id;

    // result push
    logic             push;
    logic             p_kind, p_st, p_pend, p_last;
    logic [TID_W-1:0] p_id;
    logic             out_free;

    // input field conversion
    logic [IW+TID_W-1:0] in_id_x;
    logic [IW-1:0]       in_idx;
    logic                in_bad;
    logic [CW+FIELD_W-1:0] cnt_x, ivl_x;

    // cells
    logic          cv   [NUM_TIMERS+2];
    logic [IW-1:0] cid  [NUM_TIMERS+2];
    logic [CW-1:0] cd   [NUM_TIMERS+2];
    t_cell_cmd     cmd;
    logic [IW-1:0] cpos;
    logic [CW-1:0] cx;

    logic [IW-1:0] sel;
    logic          rd_v;
    logic [IW-1:0] rd_id;
    logic [CW-1:0] rd_d;
    logic          t_stop, t_exp;
    logic          ins_here, found;

    // store ports
    logic [IW-1:0] st_addr;
    logic          dl_we, cf_we;
    logic [IW-1:0] dl_addr;
    logic [CW-1:0] dl_data;
    logic [CW-1:0] st_dl, st_sv, st_rl;
    logic [CW-1:0] start_v;

    assign in_id_x = {{IW{1'b0}}, i_in.timer_id};
    assign in_idx  = in_id_x[IW-1:0];
    assign in_bad  = (i_in.operation > OP_QUERY) ||
                     (in_id_x >= (IW+TID_W)'(NUM_TIMERS));
    assign cnt_x   = {{CW{1'b0}}, i_in.count};
    assign ivl_x   = {{CW{1'b0}}, i_in.interval};

    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_ov || o_out.ready;

    // ---- queue cells ----
    assign cv[0]             = 1'b0;
    assign cid[0]            = '0;
    assign cd[0]             = '0;
    assign cv[NUM_TIMERS+1]  = 1'b0;
    assign cid[NUM_TIMERS+1] = '0;
    assign cd[NUM_TIMERS+1]  = '0;

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
        dltq_cell #(.IDX(k), .IW(IW), .CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_pos   (cpos),
            .i_nid   (r_iid),
            .i_x     (cx),
            .i_lv    (cv[k]),
            .i_lid   (cid[k]),
            .i_ld    (cd[k]),
            .i_rv    (cv[k+2]),
            .i_rid   (cid[k+2]),
            .i_rd    (cd[k+2]),
            .o_v     (cv[k+1]),
            .o_id    (cid[k+1]),
            .o_d     (cd[k+1])
        );
    end

    assign sel = (r_state == S_TCHK) ? r_c[IW-1:0] : r_w;

    always_comb begin
        rd_v  = 1'b0;
        rd_id = '0;
        rd_d  = '0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            if (sel == IW'(k)) begin
                rd_v  = cv[k+1];
                rd_id = cid[k+1];
                rd_d  = cd[k+1];
            end
        end
    end

    assign t_stop   = (r_g == NT_X) || (r_c >= NT_X) || !rd_v;
    assign t_exp    = (rd_d <= {{(CW-1){1'b0}}, r_left});
    assign ins_here = !rd_v || (r_iv < rd_d);
    assign found    = rd_v && (rd_id == r_id);
    assign start_v  = (st_dl != '0) ? st_dl : st_sv;

    // ---- per-timer store ----
    dltq_tstore #(.NT(NUM_TIMERS), .IW(IW), .CW(CW)) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (st_addr),
        .i_dl_we     (dl_we),
        .i_dl_addr   (dl_addr),
        .i_dl_data   (dl_data),
        .i_cf_we     (cf_we),
        .i_cf_addr   (r_id),
        .i_cf_saved  (r_cnt),
        .i_cf_reload (r_ivl),
        .o_dl        (st_dl),
        .o_saved     (st_sv),
        .o_reload    (st_rl)
    );

    assign st_addr = (r_state == S_IDLE) ? in_idx :
                     (r_state == S_TCHK) ? rd_id  : r_id;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.operation == OP_TICK) n_state = S_TCHK;
                    else if (in_bad)               n_state = S_RES;
                    else                           n_state = S_OP;
                end
            end
            S_OP: begin
                case (r_op)
                    OP_START: n_state = (r_inq[r_id] || start_v == '0) ? S_RES : S_INS;
                    OP_STOP:  n_state = r_inq[r_id] ? S_FIND : S_RES;
                    OP_MODIFY: begin
                        if (r_cnt == '0)      n_state = S_RES;
                        else if (r_inq[r_id]) n_state = S_FIND;
                        else                  n_state = S_INS;
                    end
                    default:  n_state = S_RES;
                endcase
            end
            S_FIND: begin
                if (found) n_state = (r_op == OP_MODIFY) ? S_INS : S_RES;
            end
            S_INS: begin
                if (ins_here) n_state = r_tick ? S_TREP : S_RES;
            end
            S_RES: begin
                if (out_free) n_state = S_IDLE;
            end
            S_TCHK: begin
                if (t_stop || !t_exp) n_state = S_TEND;
                else                  n_state = S_TRLD;
            end
            S_TRLD: n_state = (st_rl != '0) ? S_INS : S_TREP;
            S_TREP: begin
                if (r_n >= RC_W'(RESULT_CAP) || !r_hv || out_free) n_state = S_TCHK;
            end
            S_TEND: begin
                if (!r_hv || out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- datapath and controls ----
    always_comb begin
        n_st     = r_st;
        n_w      = r_w;
        n_c      = r_c;
        n_g      = r_g;
        n_left   = r_left;
        n_n      = r_n;
        n_iv     = r_iv;
        n_iid    = r_iid;
        n_t      = r_t;
        n_tick   = r_tick;
        n_hv     = r_hv;
        n_h_id   = r_h_id;
        n_h_pend = r_h_pend;
        n_inq    = r_inq;
        cmd      = C_HOLD;
        cpos     = sel;
        cx       = r_iv;
        dl_we    = 1'b0;
        dl_addr  = r_id;
        dl_data  = rd_d;
        cf_we    = 1'b0;
        push     = 1'b0;
        p_kind   = KIND_STATUS;
        p_id     = r_id_raw;
        p_st     = r_st;
        p_pend   = r_bad ? 1'b0 : r_inq[r_id];
        p_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                n_st   = in_bad ? ST_ERR : ST_OK;
                n_w    = '0;
                n_c    = '0;
                n_g    = '0;
                n_left = 1'b1;
                n_n    = '0;
                n_hv   = 1'b0;
                n_tick = 1'b0;
                n_iid  = in_idx;
            end
            S_OP: begin
                case (r_op)
                    OP_START: begin
                        if (r_inq[r_id] || start_v == '0) n_st = ST_ERR;
                        n_iv = start_v;
                    end
                    OP_STOP: begin
                        if (!r_inq[r_id]) n_st = ST_ERR;
                    end
                    OP_MODIFY: begin
                        if (r_cnt == '0) begin
                            n_st = ST_ERR;
                        end else begin
                            cf_we = 1'b1;
                        end
                        n_iv = r_cnt;
                    end
                    default: ;
                endcase
            end
            S_FIND: begin
                if (found) begin
                    cmd          = C_REMADD;
                    dl_we        = 1'b1;
                    n_inq[r_id]  = 1'b0;
                    n_w          = '0;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_INS: begin
                if (ins_here) begin
                    cmd          = C_INSERT;
                    n_inq[r_iid] = 1'b1;
                    // the pending walk position moves back behind the newcomer
                    if (r_tick && {1'b0, r_w} <= r_c) n_c = r_c + 1'b1;
                end else begin
                    n_iv = r_iv - rd_d;
                    n_w  = r_w + 1'b1;
                end
            end
            S_RES: begin
                push = out_free;
            end
            S_TCHK: begin
                if (!t_stop) begin
                    if (t_exp) begin
                        cmd          = C_REMOVE;
                        n_left       = r_left ^ rd_d[0];
                        n_t          = rd_id;
                        n_iid        = rd_id;
                        n_inq[rd_id] = 1'b0;
                        dl_we        = 1'b1;
                        dl_addr      = rd_id;
                        dl_data      = '0;
                        n_g          = r_g + 1'b1;
                    end else begin
                        cmd = C_SUB;
                        cx  = {{(CW-1){1'b0}}, r_left};
                    end
                end
            end
            S_TRLD: begin
                n_iv   = st_rl;
                n_w    = '0;
                n_tick = 1'b1;
            end
            S_TREP: begin
                n_tick = 1'b0;
                p_kind = KIND_EXPIRY;
                p_id   = TID_W'({{TID_W{1'b0}}, r_h_id});
                p_st   = ST_OK;
                p_pend = r_h_pend;
                p_last = 1'b0;
                if (r_n < RC_W'(RESULT_CAP)) begin
                    if (!r_hv || out_free) begin
                        push     = r_hv;
                        n_hv     = 1'b1;
                        n_h_id   = r_t;
                        n_h_pend = r_inq[r_t];
                        n_n      = r_n + 1'b1;
                    end
                end
            end
            S_TEND: begin
                p_kind = KIND_EXPIRY;
                p_id   = TID_W'({{TID_W{1'b0}}, r_h_id});
                p_st   = ST_OK;
                p_pend = r_h_pend;
                p_last = 1'b1;
                if (r_hv && out_free) begin
                    push = 1'b1;
                    n_hv = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inq   <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inq   <= n_inq;
            r_hv    <= n_hv;
            if (push)             r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op     <= i_in.operation;
            r_id     <= in_idx;
            r_id_raw <= i_in.timer_id;
            r_bad    <= in_bad;
            r_cnt    <= cnt_x[CW-1:0];
            r_ivl    <= ivl_x[CW-1:0];
        end
        r_st     <= n_st;
        r_w      <= n_w;
        r_c      <= n_c;
        r_g      <= n_g;
        r_left   <= n_left;
        r_n      <= n_n;
        r_iv     <= n_iv;
        r_iid    <= n_iid;
        r_t      <= n_t;
        r_tick   <= n_tick;
        r_h_id   <= n_h_id;
        r_h_pend <= n_h_pend;
        if (push) begin
            r_o_kind <= p_kind;
            r_o_id   <= p_id;
            r_o_st   <= p_st;
            r_o_pend <= p_pend;
            r_o_last <= p_last;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.kind         = r_o_kind;
    assign o_out.timer_id_res = r_o_id;
    assign o_out.status       = r_o_st;
    assign o_out.pending      = r_o_pend;
    assign o_out.last         = r_o_last;

endmodule

### rtl/dltq_cell.sv
// ============================================================================
// dltq_cell: one slot of the expiry-ordered queue
// Holds timer id and delta; shifts with its neighbors on insert and remove.
// ============================================================================
module dltq_cell
    import dltq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic [IW-1:0] i_pos,
    input  logic [IW-1:0] i_nid,
    input  logic [CW-1:0] i_x,
    input  logic          i_lv,
    input  logic [IW-1:0] i_lid,
    input  logic [CW-1:0] i_ld,
    input  logic          i_rv,
    input  logic [IW-1:0] i_rid,
    input  logic [CW-1:0] i_rd,
    output logic          o_v,
    output logic [IW-1:0] o_id,
    output logic [CW-1:0] o_d
);

    localparam logic [IW:0] K = (IW+1)'(IDX);

    logic          r_v;
    logic [IW-1:0] r_id;
    logic [CW-1:0] r_d;
    logic [IW:0]   pos_x;
    logic [IW:0]   pos_n;

    assign pos_x = {1'b0, i_pos};
    assign pos_n = pos_x + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            case (i_cmd)
                C_REMOVE: begin
                    if (K >= pos_x) r_v <= i_rv;
                end
                C_REMADD: begin
                    if (K >= pos_x) r_v <= i_rv;
                end
                C_INSERT: begin
                    if (K == pos_x) r_v <= 1'b1;
                    else if (K > pos_x) r_v <= i_lv;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_SUB: begin
                if (K == pos_x) r_d <= r_d - i_x;
            end
            C_REMOVE: begin
                if (K >= pos_x) begin
                    r_id <= i_rid;
                    r_d  <= i_rd;
                end
            end
            C_REMADD: begin
                // successor absorbs the leaving delta
                if (K == pos_x) begin
                    r_id <= i_rid;
                    r_d  <= i_rd + r_d;
                end else if (K > pos_x) begin
                    r_id <= i_rid;
                    r_d  <= i_rd;
                end
            end
            C_INSERT: begin
                if (K == pos_x) begin
                    r_id <= i_nid;
                    r_d  <= i_x;
                end else if (K == pos_n) begin
                    r_id <= i_lid;
                    r_d  <= i_ld - i_x;
                end else if (K > pos_n) begin
                    r_id <= i_lid;
                    r_d  <= i_ld;
                end
            end
            default: ;
        endcase
    end

    assign o_v  = r_v;
    assign o_id = r_id;
    assign o_d  = r_d;

endmodule

### rtl/dltq_tstore.sv
// ============================================================================
// dltq_tstore: per-timer storage
// Parked delta, saved count and reload interval; unwritten entries read zero.
// ============================================================================
module dltq_tstore
    import dltq_pkg::*;
#(
    parameter int NT = 16,
    parameter int IW = 4,
    parameter int CW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_rd_addr,
    input  logic          i_dl_we,
    input  logic [IW-1:0] i_dl_addr,
    input  logic [CW-1:0] i_dl_data,
    input  logic          i_cf_we,
    input  logic [IW-1:0] i_cf_addr,
    input  logic [CW-1:0] i_cf_saved,
    input  logic [CW-1:0] i_cf_reload,
    output logic [CW-1:0] o_dl,
    output logic [CW-1:0] o_saved,
    output logic [CW-1:0] o_reload
);

    logic [CW-1:0] mem_dl [NT];
    logic [CW-1:0] mem_sv [NT];
    logic [CW-1:0] mem_rl [NT];
    logic [NT-1:0] r_dl_ok;
    logic [NT-1:0] r_cf_ok;
    logic [CW-1:0] r_dl_q;
    logic [CW-1:0] r_sv_q;
    logic [CW-1:0] r_rl_q;
    logic          r_dl_okq;
    logic          r_cf_okq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_ok <= '0;
            r_cf_ok <= '0;
        end else begin
            if (i_dl_we) r_dl_ok[i_dl_addr] <= 1'b1;
            if (i_cf_we) r_cf_ok[i_cf_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dl_we) mem_dl[i_dl_addr] <= i_dl_data;
        if (i_cf_we) begin
            mem_sv[i_cf_addr] <= i_cf_saved;
            mem_rl[i_cf_addr] <= i_cf_reload;
        end
        r_dl_q   <= mem_dl[i_rd_addr];
        r_sv_q   <= mem_sv[i_rd_addr];
        r_rl_q   <= mem_rl[i_rd_addr];
        r_dl_okq <= r_dl_ok[i_rd_addr];
        r_cf_okq <= r_cf_ok[i_rd_addr];
    end

    assign o_dl     = r_dl_okq ? r_dl_q : '0;
    assign o_saved  = r_cf_okq ? r_sv_q : '0;
    assign o_reload = r_cf_okq ? r_rl_q : '0;

endmodule

### bench/testbench.sv
// ============================================================================
// testbench: self-checking bench for the delta-list timer queue
// Drives random and directed operation transactions, predicts every status
// and expiry result with a behavioral timer list, and checks them in order.
// ============================================================================
module testbench;
    import dltq_pkg::*;

    localparam int NT       = 16;
    localparam int NIL      = NT;
    localparam int LIMIT    = 2000000;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  tid;
        logic [31:0] cnt;
        logic [31:0] ivl;
    } t_op_item;

    typedef struct packed {
        logic       kind;
        logic [3:0] tid;
        logic       status;
        logic       pend;
        logic       last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    dltq_in_if  in_ch ();
    dltq_out_if out_ch ();

    delta_list_timer_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // timer list mirror
    logic [31:0] tm_delta [NT];
    logic [31:0] tm_saved [NT];
    logic [31:0] tm_reload [NT];
    logic        tm_queued [NT];
    int          tm_next [NT];
    int          tm_head;

    t_op_item pending_ops[$];
    t_result  expected_results[$];
    int       mismatch_cnt;
    int       cycle_cnt;
    bit       calm;
    int       hold_off;
    bit       long_hold_done;
    bit       in_acc;

    initial begin
        i_clk = 1'b0;
    end
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    function automatic void list_unlink(input int t);
        int p;
        int g;
        p = tm_head;
        if (p == t) begin
            tm_head = tm_next[t];
        end else begin
            for (g = 0; p != NIL && g < NT; g++) begin
                if (tm_next[p] == t) begin
                    tm_next[p] = tm_next[t];
                    break;
                end
                p = tm_next[p];
            end
        end
        tm_next[t] = NIL;
        tm_queued[t] = 1'b0;
    endfunction

    function automatic void list_insert(input int t);
        int p;
        int prev;
        int g;
        p = tm_head;
        prev = NIL;
        tm_queued[t] = 1'b1;
        for (g = 0; p != NIL && g < NT; g++) begin
            if (tm_delta[t] >= tm_delta[p]) begin
                tm_delta[t] = tm_delta[t] - tm_delta[p];
                prev = p;
                p = tm_next[p];
            end else begin
                tm_delta[p] = tm_delta[p] - tm_delta[t];
                break;
            end
        end
        tm_next[t] = p;
        if (prev == NIL) tm_head = t;
        else tm_next[prev] = t;
    endfunction

    function automatic void list_stop(input int t);
        if (tm_next[t] != NIL) tm_delta[tm_next[t]] = tm_delta[tm_next[t]] + tm_delta[t];
        list_unlink(t);
    endfunction

    function automatic void predict_results(input t_op_item it);
        t_result r;
        logic [32:0] left;
        int p;
        int t;
        int g;
        int n;
        logic st;
        int id;
        id = it.tid;
        st = ST_OK;
        if (it.op == OP_TICK) begin
            left = 33'd1;
            n = 0;
            p = tm_head;
            for (g = 0; p != NIL && g < NT; g++) begin
                t = p;
                p = tm_next[t];
                if ({1'b0, tm_delta[t]} > left) begin
                    tm_delta[t] = tm_delta[t] - left[31:0];
                    break;
                end
                left = left - {1'b0, tm_delta[t]};
                tm_delta[t] = '0;
                list_unlink(t);
                if (tm_reload[t] != 0) begin
                    tm_delta[t] = tm_reload[t];
                    list_insert(t);
                end
                if (n < RESULT_CAP) begin
                    r = '{KIND_EXPIRY, t[3:0], ST_OK, tm_queued[t], 1'b0};
                    expected_results.push_back(r);
                    n++;
                end
            end
            if (n > 0) expected_results[$].last = 1'b1;
            return;
        end
        if (it.op > OP_QUERY) begin
            expected_results.push_back('{KIND_STATUS, it.tid, ST_ERR, 1'b0, 1'b1});
            return;
        end
        case (it.op)
            OP_START: begin
                if (tm_queued[id]) begin
                    st = ST_ERR;
                end else begin
                    if (tm_delta[id] == 0) tm_delta[id] = tm_saved[id];
                    if (tm_delta[id] == 0) st = ST_ERR;
                    else list_insert(id);
                end
            end
            OP_STOP: begin
                if (!tm_queued[id]) st = ST_ERR;
                else list_stop(id);
            end
            OP_MODIFY: begin
                if (it.cnt == 0) begin
                    st = ST_ERR;
                end else begin
                    if (tm_queued[id]) list_stop(id);
                    tm_saved[id] = it.cnt;
                    tm_delta[id] = it.cnt;
                    tm_reload[id] = it.ivl;
                    list_insert(id);
                end
            end
            default: ;
        endcase
        expected_results.push_back('{KIND_STATUS, it.tid, st, tm_queued[id], 1'b1});
    endfunction

    function automatic t_op_item make_op(input logic [2:0] op, input int tid,
                                         input logic [31:0] cnt, input logic [31:0] ivl);
        t_op_item it;
        it.op = op;
        it.tid = tid[3:0];
        it.cnt = cnt;
        it.ivl = ivl;
        return it;
    endfunction

    // stimulus
    initial begin
        int i;
        int k;
        int tid;
        int sel;
        logic [31:0] c;
        logic [31:0] v;
        for (i = 0; i < NT; i++) begin
            tm_delta[i] = '0;
            tm_saved[i] = '0;
            tm_reload[i] = '0;
            tm_queued[i] = 1'b0;
            tm_next[i] = NIL;
        end
        tm_head = NIL;
        calm = 1'b0;
        // directed part
        pending_ops.push_back(make_op(OP_TICK, 0, 0, 0));
        pending_ops.push_back(make_op(OP_START, 0, 0, 0));
        pending_ops.push_back(make_op(OP_STOP, 1, 0, 0));
        pending_ops.push_back(make_op(OP_MODIFY, 2, 0, 5));
        pending_ops.push_back(make_op(OP_MODIFY, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(OP_MODIFY, 3, 1, 0));
        pending_ops.push_back(make_op(OP_MODIFY, 4, 2, 2));
        pending_ops.push_back(make_op(OP_START, 3, 0, 0));
        pending_ops.push_back(make_op(OP_QUERY, 3, 0, 0));
        pending_ops.push_back(make_op(OP_TICK, 9, 32'hFFFF_FFFF, 0));
        pending_ops.push_back(make_op(OP_START, 3, 0, 0));
        pending_ops.push_back(make_op(OP_STOP, 15, 0, 0));
        pending_ops.push_back(make_op(OP_START, 15, 0, 0));
        pending_ops.push_back(make_op(3'd5, 7, 0, 0));
        pending_ops.push_back(make_op(3'd7, 15, 32'hFFFF_FFFF, 1));
        // all sixteen expire on one tick: many-expiry case
        for (i = 0; i < NT; i++) pending_ops.push_back(make_op(OP_MODIFY, i, 1, i % 2));
        pending_ops.push_back(make_op(OP_TICK, 0, 0, 0));
        // random part: mostly small counts so ticks yield expiries
        for (k = 0; k < 428; k++) begin
            sel = $urandom_range(0, 99);
            tid = $urandom_range(0, NT - 1);
            c = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
            v = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
            if (sel < 40) pending_ops.push_back(make_op(OP_TICK, tid, $urandom(), $urandom()));
            else if (sel < 60) pending_ops.push_back(make_op(OP_START, tid, c, v));
            else if (sel < 70) pending_ops.push_back(make_op(OP_STOP, tid, c, v));
            else if (sel < 88) pending_ops.push_back(make_op(OP_MODIFY, tid, c, v));
            else if (sel < 97) pending_ops.push_back(make_op(OP_QUERY, tid, c, v));
            else pending_ops.push_back(make_op(3'($urandom_range(5, 7)), tid, c, v));
        end
    end

    // sender
    int send_gap;
    int sent_cnt;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_ch.valid && !in_acc) begin
                // hold the offered transaction
            end else if (send_gap > 0) begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_ops.size() > 0) begin
                if (!calm && $urandom_range(0, 19) == 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap <= $urandom_range(1, 16);
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.operation <= pending_ops[0].op;
                    in_ch.timer_id <= pending_ops[0].tid;
                    in_ch.count <= pending_ops[0].cnt;
                    in_ch.interval <= pending_ops[0].ivl;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver readiness, with one long hold-off
    int recv_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
            hold_off <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (sent_cnt == 40 && !long_hold_done) begin
            hold_off <= 400;
            long_hold_done <= 1'b1;
            out_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            out_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            out_ch.ready <= 1'b0;
            recv_gap <= $urandom_range(1, 16);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor
    t_result got;
    t_result want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sent_cnt <= 0;
            in_acc <= 1'b0;
        end else begin
            in_acc <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                predict_results('{in_ch.operation, in_ch.timer_id, in_ch.count,
                                  in_ch.interval});
                void'(pending_ops.pop_front());
                sent_cnt <= sent_cnt + 1;
                if (pending_ops.size() < 60) calm <= 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.kind, out_ch.timer_id_res, out_ch.status,
                        out_ch.pending, out_ch.last};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind %b exp %b", got.kind, want.kind));
                    if (got.tid !== want.tid)
                        report_mismatch($sformatf("timer %0d exp %0d", got.tid, want.tid));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %b exp %b t%0d", got.status,
                                                  want.status, want.tid));
                    if (got.pend !== want.pend)
                        report_mismatch($sformatf("pending %b exp %b t%0d", got.pend,
                                                  want.pend, want.tid));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b exp %b t%0d", got.last,
                                                  want.last, want.tid));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("FAIL delta_list_timer_queue");
            $finish;
        end
    end

    initial begin
        cycle_cnt = 0;
        mismatch_cnt = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.timer_id = '0;
        in_ch.count = '0;
        in_ch.interval = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_ops.size() == 0 && sent_cnt > 0);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("PASS delta_list_timer_queue");
        end else begin
            $display("FAIL delta_list_timer_queue");
        end
        $finish;
    end

endmodule
